FILE: src/fen_string_validator_defines.svh
// ----------------------------------------------------------------------------
// FEN string validator assertion macros
// Concurrent assertion shorthands used by the validator top level.
// ----------------------------------------------------------------------------
`ifndef FEN_STRING_VALIDATOR_DEFINES_SVH
`define FEN_STRING_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define FSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fen_string_validator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fen_string_validator: next-cycle check failed");

`else

`define FSV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/fsv_pkg.sv
// ----------------------------------------------------------------------------
// FEN string validator package
// Parse state type, character codes and token positions.
// ----------------------------------------------------------------------------
package fsv_pkg;

    // Parse state carried from one byte to the next.
    typedef struct packed {
        logic [2:0] token_index;
        logic       inside_token;
        logic       failed;
        logic [3:0] rank_fill;
        logic [3:0] ranks_done;
        logic [1:0] token_length;
        logic [7:0] first_byte;
        logic [7:0] previous_byte;
    } t_state;

    localparam t_state STATE_RESET = '0;

    // Token positions within the record.
    localparam logic [2:0] TOK_BOARD     = 3'd0;
    localparam logic [2:0] TOK_SIDE      = 3'd1;
    localparam logic [2:0] TOK_CASTLING  = 3'd2;
    localparam logic [2:0] TOK_EN_PASSANT = 3'd3;
    localparam logic [2:0] TOK_HALFMOVE  = 3'd4;
    localparam logic [2:0] TOK_FULLMOVE  = 3'd5;
    localparam logic [2:0] TOKEN_COUNT   = 3'd6;

    // Board geometry.
    localparam logic [3:0] RANK_SQUARES = 4'd8;
    localparam logic [3:0] RANK_COUNT   = 4'd8;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_H_LO  = 8'h68;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_K_UP  = 8'h4B;
    localparam logic [7:0] CH_Q_UP  = 8'h51;
    localparam logic [7:0] CH_K_LO  = 8'h6B;
    localparam logic [7:0] CH_Q_LO  = 8'h71;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_N_UP  = 8'h4E;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_P_LO  = 8'h70;
    localparam logic [7:0] CH_N_LO  = 8'h6E;
    localparam logic [7:0] CH_R_LO  = 8'h72;

endpackage

FILE: src/fsv_step.sv
// ----------------------------------------------------------------------------
// FEN string validator step logic
// Combinational update of the parse state for one byte, plus the verdict.
// ----------------------------------------------------------------------------
module fsv_step (
    input  fsv_pkg::t_state i_state,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    output fsv_pkg::t_state o_next_state,
    output logic            o_verdict
);

    // A non-space byte: open a token if needed, then check it for its token.
    function automatic fsv_pkg::t_state f_token_byte(fsv_pkg::t_state s, logic [7:0] c);
        fsv_pkg::t_state r;
        logic [4:0]      v_add;
        logic [4:0]      v_sum;
        logic            v_ok;
        r     = s;
        v_add = 5'd0;
        v_sum = 5'd0;
        v_ok  = 1'b1;
        if (!r.inside_token && r.token_index >= fsv_pkg::TOKEN_COUNT) begin
            // A seventh token fails the string at its first byte.
            r.failed = 1'b1;
        end else begin
            if (!r.inside_token) begin
                r.inside_token = 1'b1;
                r.token_length = 2'd0;
                r.first_byte   = c;
                r.rank_fill    = 4'd0;
                r.ranks_done   = 4'd0;
            end
            case (r.token_index)
                fsv_pkg::TOK_BOARD: begin
                    if (c == fsv_pkg::CH_SLASH) begin
                        // A slash closes a full rank.
                        if (r.rank_fill != fsv_pkg::RANK_SQUARES ||
                            r.ranks_done >= fsv_pkg::RANK_COUNT) begin
                            r.failed = 1'b1;
                        end else begin
                            r.ranks_done = r.ranks_done + 4'd1;
                            r.rank_fill  = 4'd0;
                        end
                    end else begin
                        if (c inside {[fsv_pkg::CH_1:fsv_pkg::CH_8]}) begin
                            v_add = {1'b0, c[3:0]};
                        end else if (c inside {fsv_pkg::CH_P_UP, fsv_pkg::CH_N_UP,
                                               fsv_pkg::CH_B_UP, fsv_pkg::CH_R_UP,
                                               fsv_pkg::CH_Q_UP, fsv_pkg::CH_K_UP,
                                               fsv_pkg::CH_P_LO, fsv_pkg::CH_N_LO,
                                               fsv_pkg::CH_B,    fsv_pkg::CH_R_LO,
                                               fsv_pkg::CH_Q_LO, fsv_pkg::CH_K_LO}) begin
                            v_add = 5'd1;
                        end else begin
                            v_ok = 1'b0;
                        end
                        v_sum = {1'b0, r.rank_fill} + v_add;
                        if (!v_ok || v_sum > {1'b0, fsv_pkg::RANK_SQUARES}) begin
                            r.failed = 1'b1;
                        end else begin
                            r.rank_fill = v_sum[3:0];
                        end
                    end
                end
                fsv_pkg::TOK_CASTLING: begin
                    // A dash is allowed only as the first byte.
                    if (!(c inside {fsv_pkg::CH_K_UP, fsv_pkg::CH_Q_UP,
                                    fsv_pkg::CH_K_LO, fsv_pkg::CH_Q_LO} ||
                          (c == fsv_pkg::CH_DASH && r.token_length == 2'd0))) begin
                        r.failed = 1'b1;
                    end
                end
                fsv_pkg::TOK_HALFMOVE, fsv_pkg::TOK_FULLMOVE: begin
                    if (!(c inside {[fsv_pkg::CH_0:fsv_pkg::CH_9]})) begin
                        r.failed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (r.token_length != 2'd3) begin
                r.token_length = r.token_length + 2'd1;
            end
            r.previous_byte = c;
        end
        return r;
    endfunction

    // Close the open token, if any, and apply the end-of-token checks.
    function automatic fsv_pkg::t_state f_close(fsv_pkg::t_state s);
        fsv_pkg::t_state r;
        logic            v_dash;
        r      = s;
        v_dash = (r.token_length == 2'd1) && (r.first_byte == fsv_pkg::CH_DASH);
        if (r.inside_token) begin
            r.inside_token = 1'b0;
            case (r.token_index)
                fsv_pkg::TOK_BOARD: begin
                    // A partial last rank counts if it is full.
                    if (r.rank_fill != 4'd0) begin
                        if (r.rank_fill != fsv_pkg::RANK_SQUARES) begin
                            r.failed = 1'b1;
                        end else begin
                            r.ranks_done = r.ranks_done + 4'd1;
                        end
                    end
                    if (r.ranks_done != fsv_pkg::RANK_COUNT) begin
                        r.failed = 1'b1;
                    end
                end
                fsv_pkg::TOK_SIDE: begin
                    if (!(r.token_length == 2'd1 &&
                          (r.first_byte == fsv_pkg::CH_W || r.first_byte == fsv_pkg::CH_B))) begin
                        r.failed = 1'b1;
                    end
                end
                fsv_pkg::TOK_CASTLING: begin
                    if (r.first_byte == fsv_pkg::CH_DASH && r.token_length != 2'd1) begin
                        r.failed = 1'b1;
                    end
                end
                fsv_pkg::TOK_EN_PASSANT: begin
                    if (!(v_dash ||
                          (r.token_length == 2'd2 &&
                           r.first_byte inside {[fsv_pkg::CH_A_LO:fsv_pkg::CH_H_LO]} &&
                           (r.previous_byte == fsv_pkg::CH_3 ||
                            r.previous_byte == fsv_pkg::CH_6)))) begin
                        r.failed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            r.token_index = r.token_index + 3'd1;
        end
        return r;
    endfunction

    fsv_pkg::t_state w_after_byte;
    fsv_pkg::t_state w_after_close;
    logic            w_space;

    // Update for the byte itself.
    always_comb begin
        w_space = (i_char == fsv_pkg::CH_SPACE) ||
                  (i_char inside {[fsv_pkg::CH_TAB:fsv_pkg::CH_CR]});
        if (i_state.failed) begin
            w_after_byte = i_state;
        end else if (w_space) begin
            w_after_byte = f_close(i_state);
        end else begin
            w_after_byte = f_token_byte(i_state, i_char);
        end
    end

    // On the last byte, close the final token, give the verdict and restart.
    always_comb begin
        if (w_after_byte.failed) begin
            w_after_close = w_after_byte;
        end else begin
            w_after_close = f_close(w_after_byte);
        end
        o_verdict = !w_after_close.failed &&
                    (w_after_close.token_index == fsv_pkg::TOKEN_COUNT);
        o_next_state = i_last ? fsv_pkg::STATE_RESET : w_after_byte;
    end

endmodule

FILE: src/fen_string_validator.sv
// Result: registered in the output register once the last byte leaves the input register.
// Throughput: one byte per cycle, unless a last byte waits for room in the output register.
// A result waiting in the output register does not stall bytes that give no result.
// Reset: synchronous, active low; clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
// FEN string validator top level
// Input register, parse state update, and output result register.
// ----------------------------------------------------------------------------
`include "fen_string_validator_defines.svh"

module fen_string_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_well_formed
);

    logic            r_in_valid;
    logic [7:0]      r_in_char;
    logic            r_in_last;
    fsv_pkg::t_state r_state;
    fsv_pkg::t_state n_state;
    logic            r_out_valid;
    logic            r_well_formed;
    logic            w_verdict;
    logic            w_out_free;
    logic            w_consume;

    // Per-byte parse logic.
    fsv_step u_step (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .o_next_state (n_state),
        .o_verdict    (w_verdict)
    );

    // Handshake: a byte leaves the input register unless its result has no room.
    always_comb begin
        w_out_free = !r_out_valid || i_ready;
        w_consume  = r_in_valid && (!r_in_last || w_out_free);
        o_ready    = !r_in_valid || w_consume;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= fsv_pkg::STATE_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_consume) begin
                r_state <= n_state;
            end
            if (w_consume && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_char_byte;
            r_in_last <= i_is_last;
        end
        if (w_consume && r_in_last) begin
            r_well_formed <= w_verdict;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_well_formed = r_well_formed;

    // Checks on the internal pipeline.
    `FSV_ASSERT_SAME(a_last_stalls_input, i_clk, i_rst_n, r_in_valid && r_in_last && r_out_valid && !i_ready, !o_ready)
    `FSV_ASSERT_NEXT(a_last_makes_result, i_clk, i_rst_n, w_consume && r_in_last, o_valid && r_state.token_index == fsv_pkg::TOKEN_COUNT - fsv_pkg::TOKEN_COUNT && !r_state.failed && !r_state.inside_token)
    `FSV_ASSERT_SAME(a_token_count_bound, i_clk, i_rst_n, 1'b1, r_state.token_index <= fsv_pkg::TOKEN_COUNT)

endmodule

FILE: bench/fen_verdict_checker.sv
// ----------------------------------------------------------------------------
// FEN verdict checker
// Watches the byte and verdict channels of the validator, keeps its own
// parse state to predict the verdict of each string, and compares every
// verdict transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module fen_verdict_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic       i_byte_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_is_last,
    input  logic       i_verdict_valid,
    input  logic       i_verdict_ready,
    input  logic       i_well_formed,
    output int         o_mismatches,
    output int         o_backlog
);

    typedef logic [7:0] t_byte;

    // Parse state of the string in flight and the verdicts not yet seen.
    fsv_pkg::t_state parse;
    logic            verdicts_due[$];

    // C whitespace: space, tab, line feed, vertical tab, form feed, return.
    function automatic logic is_blank(t_byte c);
        return (c == fsv_pkg::CH_SPACE) || (c >= fsv_pkg::CH_TAB && c <= fsv_pkg::CH_CR);
    endfunction

    function automatic logic is_piece_letter(t_byte c);
        case (c)
            fsv_pkg::CH_P_LO, fsv_pkg::CH_N_LO, fsv_pkg::CH_B, fsv_pkg::CH_R_LO,
            fsv_pkg::CH_Q_LO, fsv_pkg::CH_K_LO, fsv_pkg::CH_P_UP, fsv_pkg::CH_N_UP,
            fsv_pkg::CH_B_UP, fsv_pkg::CH_R_UP, fsv_pkg::CH_Q_UP, fsv_pkg::CH_K_UP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // One byte of the board token: slashes close ranks, digits and pieces fill them.
    function automatic void board_char(t_byte c);
        int add;
        if (c == fsv_pkg::CH_SLASH) begin
            if (parse.rank_fill != fsv_pkg::RANK_SQUARES ||
                parse.ranks_done >= fsv_pkg::RANK_COUNT) begin
                parse.failed = 1'b1;
            end else begin
                parse.ranks_done = parse.ranks_done + 4'd1;
                parse.rank_fill  = '0;
            end
            return;
        end
        if (c >= fsv_pkg::CH_1 && c <= fsv_pkg::CH_8) begin
            add = int'(c) - int'(fsv_pkg::CH_0);
        end else if (is_piece_letter(c)) begin
            add = 1;
        end else begin
            parse.failed = 1'b1;
            return;
        end
        if (int'(parse.rank_fill) + add > int'(fsv_pkg::RANK_SQUARES)) begin
            parse.failed = 1'b1;
        end else begin
            parse.rank_fill = parse.rank_fill + 4'(add);
        end
    endfunction

    // A byte that belongs to a token; opening a seventh token fails the string.
    function automatic void take_char(t_byte c);
        if (!parse.inside_token) begin
            if (parse.token_index >= fsv_pkg::TOKEN_COUNT) begin
                parse.failed = 1'b1;
                return;
            end
            parse.inside_token = 1'b1;
            parse.token_length = '0;
            parse.first_byte   = c;
            parse.rank_fill    = '0;
            parse.ranks_done   = '0;
        end
        case (parse.token_index)
            fsv_pkg::TOK_BOARD: begin
                board_char(c);
            end
            fsv_pkg::TOK_CASTLING: begin
                if (!(c == fsv_pkg::CH_K_UP || c == fsv_pkg::CH_Q_UP ||
                      c == fsv_pkg::CH_K_LO || c == fsv_pkg::CH_Q_LO ||
                      (c == fsv_pkg::CH_DASH && parse.token_length == 2'd0))) begin
                    parse.failed = 1'b1;
                end
            end
            fsv_pkg::TOK_HALFMOVE, fsv_pkg::TOK_FULLMOVE: begin
                if (!(c >= fsv_pkg::CH_0 && c <= fsv_pkg::CH_9)) begin
                    parse.failed = 1'b1;
                end
            end
            default: ;
        endcase
        if (parse.token_length != 2'd3) begin
            parse.token_length = parse.token_length + 2'd1;
        end
        parse.previous_byte = c;
    endfunction

    // Whole-token checks made when a token ends.
    function automatic void end_token();
        logic dash;
        dash = (parse.token_length == 2'd1) && (parse.first_byte == fsv_pkg::CH_DASH);
        if (!parse.inside_token) begin
            return;
        end
        parse.inside_token = 1'b0;
        case (parse.token_index)
            fsv_pkg::TOK_BOARD: begin
                if (parse.rank_fill != '0) begin
                    if (parse.rank_fill != fsv_pkg::RANK_SQUARES) begin
                        parse.failed = 1'b1;
                    end else begin
                        parse.ranks_done = parse.ranks_done + 4'd1;
                    end
                end
                if (parse.ranks_done != fsv_pkg::RANK_COUNT) begin
                    parse.failed = 1'b1;
                end
            end
            fsv_pkg::TOK_SIDE: begin
                if (!(parse.token_length == 2'd1 &&
                      (parse.first_byte == fsv_pkg::CH_W ||
                       parse.first_byte == fsv_pkg::CH_B))) begin
                    parse.failed = 1'b1;
                end
            end
            fsv_pkg::TOK_CASTLING: begin
                if (parse.first_byte == fsv_pkg::CH_DASH && parse.token_length != 2'd1) begin
                    parse.failed = 1'b1;
                end
            end
            fsv_pkg::TOK_EN_PASSANT: begin
                if (!(dash || (parse.token_length == 2'd2 &&
                               parse.first_byte >= fsv_pkg::CH_A_LO &&
                               parse.first_byte <= fsv_pkg::CH_H_LO &&
                               (parse.previous_byte == fsv_pkg::CH_3 ||
                                parse.previous_byte == fsv_pkg::CH_6)))) begin
                    parse.failed = 1'b1;
                end
            end
            default: ;
        endcase
        parse.token_index = parse.token_index + 3'd1;
    endfunction

    // Compare verdicts first, then fold in the byte accepted at the same edge.
    always @(posedge i_clk) begin
        logic wanted;
        if (!i_rst_n) begin
            parse = fsv_pkg::STATE_RESET;
            verdicts_due.delete();
            o_mismatches = 0;
            o_backlog    = 0;
        end else begin
            if (i_verdict_valid && i_verdict_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("well_formed: no verdict expected, actual %0b", i_well_formed);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    wanted = verdicts_due.pop_front();
                    if (i_well_formed !== wanted) begin
                        $error("well_formed: expected %0b, actual %0b", wanted, i_well_formed);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                if (!parse.failed) begin
                    if (is_blank(i_char_byte)) begin
                        end_token();
                    end else begin
                        take_char(i_char_byte);
                    end
                end
                if (i_is_last) begin
                    if (!parse.failed) begin
                        end_token();
                    end
                    verdicts_due.push_back(!parse.failed &&
                                           parse.token_index == fsv_pkg::TOKEN_COUNT);
                    parse = fsv_pkg::STATE_RESET;
                end
            end
            o_backlog = verdicts_due.size();
        end
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// FEN string validator testbench
// Streams position strings into the validator one byte per transaction:
// a directed set of edge cases, then random well-formed records, mutated
// records and byte noise, with random input gaps and verdict stalls.
// ----------------------------------------------------------------------------
module tb;

    typedef logic [7:0] t_byte;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int BYTE_BUDGET    = 1600;
    localparam int QUIET_TAIL     = 1400;

    logic  i_clk         = 1'b0;
    logic  i_rst_n       = 1'b0;
    logic  byte_valid    = 1'b0;
    logic  byte_ready;
    t_byte char_byte     = '0;
    logic  is_last       = 1'b0;
    logic  verdict_valid;
    logic  verdict_ready = 1'b0;
    logic  well_formed;

    int    mismatches;
    int    backlog;
    int    quiet_cycles  = 0;
    int    stall_left    = 0;
    int    bytes_sent    = 0;
    bit    send_gaps     = 1'b0;
    bit    take_stalls   = 1'b0;
    t_byte text_bytes[$];

    localparam t_byte PIECES[12] = '{fsv_pkg::CH_P_LO, fsv_pkg::CH_N_LO, fsv_pkg::CH_B,
                                     fsv_pkg::CH_R_LO, fsv_pkg::CH_Q_LO, fsv_pkg::CH_K_LO,
                                     fsv_pkg::CH_P_UP, fsv_pkg::CH_N_UP, fsv_pkg::CH_B_UP,
                                     fsv_pkg::CH_R_UP, fsv_pkg::CH_Q_UP, fsv_pkg::CH_K_UP};
    localparam t_byte CASTLE_RIGHTS[4] = '{fsv_pkg::CH_K_UP, fsv_pkg::CH_Q_UP,
                                           fsv_pkg::CH_K_LO, fsv_pkg::CH_Q_LO};

    always #5 i_clk = ~i_clk;

    fen_string_validator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (byte_valid),
        .o_ready       (byte_ready),
        .i_char_byte   (char_byte),
        .i_is_last     (is_last),
        .o_valid       (verdict_valid),
        .i_ready       (verdict_ready),
        .o_well_formed (well_formed)
    );

    fen_verdict_checker verdict_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_valid    (byte_valid),
        .i_byte_ready    (byte_ready),
        .i_char_byte     (char_byte),
        .i_is_last       (is_last),
        .i_verdict_valid (verdict_valid),
        .i_verdict_ready (verdict_ready),
        .i_well_formed   (well_formed),
        .o_mismatches    (mismatches),
        .o_backlog       (backlog)
    );

    // Verdict side stalls in random bursts.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            verdict_ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (take_stalls && $urandom_range(0, 2) == 0) begin
            verdict_ready <= 1'b0;
            stall_left    <= $urandom_range(0, 4);
        end else begin
            verdict_ready <= 1'b1;
        end
    end

    // End the run if no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_valid && byte_ready) || (verdict_valid && verdict_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Send one byte, with an optional gap before it, and wait for acceptance.
    task automatic put_byte(input t_byte c, input logic last);
        int gap;
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                byte_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        byte_valid <= 1'b1;
        char_byte  <= c;
        is_last    <= last;
        @(posedge i_clk);
        while (!byte_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text_bytes();
        for (int i = 0; i < text_bytes.size(); i++) begin
            put_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    // Drop the byte channel and hold it until every verdict in flight has come out.
    task automatic drain_verdicts();
        @(negedge i_clk);
        byte_valid <= 1'b0;
        while (backlog != 0) @(negedge i_clk);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_bytes.push_back(t_byte'(s[i]));
        end
    endfunction

    task automatic send_text(string s);
        text_bytes.delete();
        add_text(s);
        send_text_bytes();
    endtask

    function automatic t_byte pick_blank();
        if ($urandom_range(0, 2) == 0) begin
            return fsv_pkg::CH_SPACE;
        end
        return fsv_pkg::CH_TAB + t_byte'($urandom_range(0, 4));
    endfunction

    function automatic void add_blanks();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) text_bytes.push_back(pick_blank());
    endfunction

    // Eight ranks that each sum to eight squares, sometimes with a trailing slash.
    function automatic void add_board();
        int fill;
        int run;
        for (int r = 0; r < 8; r++) begin
            fill = 0;
            while (fill < 8) begin
                if ($urandom_range(0, 1) == 0) begin
                    text_bytes.push_back(PIECES[$urandom_range(0, 11)]);
                    fill++;
                end else begin
                    run = $urandom_range(1, 8 - fill);
                    text_bytes.push_back(fsv_pkg::CH_0 + t_byte'(run));
                    fill += run;
                end
            end
            if (r != 7 || $urandom_range(0, 3) == 0) begin
                text_bytes.push_back(fsv_pkg::CH_SLASH);
            end
        end
    endfunction

    function automatic void add_digits(int n);
        repeat (n) text_bytes.push_back(fsv_pkg::CH_0 + t_byte'($urandom_range(0, 9)));
    endfunction

    function automatic t_byte pick_token_char();
        case ($urandom_range(0, 6))
            0: return fsv_pkg::CH_SLASH;
            1: return fsv_pkg::CH_DASH;
            2: return fsv_pkg::CH_0 + t_byte'($urandom_range(0, 9));
            3: return PIECES[$urandom_range(0, 11)];
            4: return pick_blank();
            5: return fsv_pkg::CH_A_LO + t_byte'($urandom_range(0, 8));
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    // A random well-formed record, often damaged in one place, or now and then pure byte noise.
    function automatic void make_record();
        int n;
        int pos;
        text_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 16);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) begin
                    text_bytes.push_back(t_byte'($urandom_range(0, 255)));
                end else begin
                    text_bytes.push_back(pick_token_char());
                end
            end
            return;
        end
        if ($urandom_range(0, 3) == 0) add_blanks();
        add_board();
        add_blanks();
        text_bytes.push_back(($urandom_range(0, 1) == 0) ? fsv_pkg::CH_W : fsv_pkg::CH_B);
        add_blanks();
        if ($urandom_range(0, 2) == 0) begin
            text_bytes.push_back(fsv_pkg::CH_DASH);
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) text_bytes.push_back(CASTLE_RIGHTS[$urandom_range(0, 3)]);
        end
        add_blanks();
        if ($urandom_range(0, 1) == 0) begin
            text_bytes.push_back(fsv_pkg::CH_DASH);
        end else begin
            text_bytes.push_back(fsv_pkg::CH_A_LO + t_byte'($urandom_range(0, 7)));
            text_bytes.push_back(($urandom_range(0, 1) == 0) ? fsv_pkg::CH_3 : fsv_pkg::CH_6);
        end
        add_blanks();
        add_digits(($urandom_range(0, 7) == 0) ? 12 : $urandom_range(1, 3));
        add_blanks();
        add_digits($urandom_range(1, 4));
        if ($urandom_range(0, 3) == 0) add_blanks();

        pos = $urandom_range(0, text_bytes.size() - 1);
        case ($urandom_range(0, 11))
            0: text_bytes[pos] = t_byte'($urandom_range(0, 255));
            1: text_bytes[pos] = pick_token_char();
            2: text_bytes.insert(pos, pick_token_char());
            3: text_bytes.delete(pos);
            4: begin
                add_blanks();
                text_bytes.push_back(pick_token_char());
            end
            5: begin
                while (text_bytes.size() > pos + 1) void'(text_bytes.pop_back());
            end
            default: ;
        endcase
    endfunction

    // Stimulus: reset, directed strings, then random records to the byte budget.
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gaps   = 1'b1;
        take_stalls = 1'b1;
        send_text("8/8/8/8/8/8/8/8 w - - 0 1");
        send_text("rnbqkbnr/pppppppp/8/8/8/8/PPPPPPPP/RNBQKBNR w KQkq - 0 1");
        // Trailing slash on the board and a long castling run.
        send_text("r3k2r/8/8/3pP3/8/8/8/R3K2R/ b KQkqKQ e3 12 345");
        // Every kind of whitespace, in runs, leading and trailing.
        send_text("\t\n 8/8/8/8/44/8/8/7p\013\014w \015-  h6\t00000000000099999 7 \n");
        send_text("8/8/8/8/8/8/8/8 w - - 0 1 x");
        send_text("  \t\n");
        send_text(" ");
        send_text("w");
        send_text("8/8/8/8/8/8/8/8 w - - 0");
        send_text("9/8/8/8/8/8/8/8 w - - 0 1");
        send_text("p8/0/8/8/8/8/8/8 b - - 0 1");
        send_text("8/8/8/8/8/8/8 w - - 0 1");
        send_text("8/8/8/8/8/8/8/8/8 w - - 0 1");
        send_text("8/8/8/8/8/8/8/8// w - - 0 1");
        send_text("8/8/8/8/8/8/8/8 w -K - 0 1");
        send_text("8/8/8/8/8/8/8/8 b -- a3 0 1");
        send_text("8/8/8/8/8/8/8/8 w Kq i3 0 1");
        send_text("8/8/8/8/8/8/8/8 w k a3x 0 1");
        send_text("8/8/8/8/8/8/8/8 W - - 0 1");
        send_text("8/8/8/8/8/8/8/8 b - -- 1a 0");
        // Control and high bytes are ordinary characters, invalid everywhere.
        text_bytes.delete();
        add_text("8/8/8/8/8/8/8/8 w");
        text_bytes.push_back(8'h00);
        add_text(" - - 0 1");
        send_text_bytes();
        text_bytes.delete();
        add_text("8/8/8/8/8/8/8/8 b - - 0 1");
        text_bytes.push_back(8'hFF);
        send_text_bytes();
        drain_verdicts();

        for (int rec = 0; bytes_sent < BYTE_BUDGET; rec++) begin
            send_gaps   = (bytes_sent < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            take_stalls = (bytes_sent < QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (rec == 20) drain_verdicts();
            make_record();
            send_text_bytes();
        end
        send_gaps   = 1'b0;
        take_stalls = 1'b0;
        @(negedge i_clk);
        byte_valid <= 1'b0;
        is_last    <= 1'b0;

        drain_verdicts();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
